// File: sv/assert_macros.svh
// assertion macros shared by the decoder rtl
// expects a clock i_clk and an active-low reset i_rst_n in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/visa_pkg.sv
// types, codes and opcode/format tables of the vector isa decoder
// no dependencies
`default_nettype none

package visa_pkg;

    // instruction class codes
    typedef enum logic [2:0] {
        CLS_NOP   = 3'd0,
        CLS_A     = 3'd1,
        CLS_B     = 3'd2,
        CLS_C     = 3'd3,
        CLS_D     = 3'd4,
        CLS_E     = 3'd5,
        CLS_UNDEF = 3'd6
    } t_fmt_class;

    // arithmetic opcodes with special handling
    localparam logic [5:0] OPC_OR      = 6'd0;
    localparam logic [5:0] OPC_SHUFFLE = 6'd13;
    localparam logic [5:0] OPC_MOVE    = 6'd15;
    localparam logic [5:0] OPC_GETLANE = 6'd26;
    localparam logic [5:0] OPC_FTOI    = 6'd27;
    localparam logic [5:0] OPC_ITOF    = 6'd42;

    // memory ops
    localparam logic [3:0] MOP_LOAD_S8  = 4'd1;
    localparam logic [3:0] MOP_LOAD_S16 = 4'd3;
    localparam logic [3:0] MOP_CTRL     = 4'd6;

    // memory access kinds
    localparam logic [1:0] ACC_SCALAR = 2'd0;
    localparam logic [1:0] ACC_GATHER = 2'd3;

    // cache control and branch types
    localparam logic [2:0] DTYPE_BARRIER  = 3'd4;
    localparam logic [2:0] ETYPE_GOTO     = 3'd3;
    localparam logic [2:0] ETYPE_CALL     = 3'd4;
    localparam logic [2:0] ETYPE_CALL_REG = 3'd6;
    localparam logic [2:0] ETYPE_LAST     = 3'd6;

    // stream widths
    localparam int IN_W  = 64;
    localparam int OUT_W = 96;

    // decoded fields of one instruction
    typedef struct packed {
        t_fmt_class  fmt_class;
        logic [5:0]  op_code;
        logic [4:0]  dest_reg;
        logic [4:0]  src1_reg;
        logic [4:0]  src2_reg;
        logic [4:0]  mask_reg;
        logic [19:0] immediate;
        logic [2:0]  operand_kinds;
        logic [1:0]  mask_mode;
        logic [4:0]  type_flags;
        logic [3:0]  memory_kind;
    } t_dec_fields;

    function automatic logic op_is_float(input logic [5:0] op);
        return op == 6'd27 || op == 6'd28 || (op >= 6'd32 && op <= 6'd35) ||
               op == 6'd38 || op == 6'd39 || op == 6'd41 || op == 6'd42 ||
               (op >= 6'd44 && op <= 6'd47);
    endfunction

    function automatic logic op_is_cmp(input logic [5:0] op);
        return (op >= 6'd16 && op <= 6'd26) || (op >= 6'd44 && op <= 6'd47);
    endfunction

    function automatic logic op_is_uns(input logic [5:0] op);
        return (op >= 6'd22 && op <= 6'd25) || op == 6'd10;
    endfunction

    // a/b format: masked variants
    function automatic logic fmt_masked(input logic [2:0] f);
        return f == 3'd2 || f == 3'd3 || f == 3'd5 || f == 3'd6;
    endfunction

    // a/b format: inverted mask variants
    function automatic logic fmt_inverted(input logic [2:0] f);
        return f == 3'd3 || f == 3'd6;
    endfunction

    // b format: scalar first operand
    function automatic logic b_op1_scalar(input logic [2:0] f);
        return f == 3'd0 || f == 3'd4 || f == 3'd5 || f == 3'd6;
    endfunction

    // c format: access kind per memory op
    function automatic logic [1:0] mem_access(input logic [3:0] op);
        logic [1:0] acc;
        case (op)
            4'd7, 4'd8, 4'd9:    acc = 2'd1;
            4'd10, 4'd11, 4'd12: acc = 2'd2;
            4'd13, 4'd14, 4'd15: acc = 2'd3;
            default:             acc = 2'd0;
        endcase
        return acc;
    endfunction

    function automatic logic mem_masked(input logic [3:0] op);
        return op == 4'd8 || op == 4'd9 || op == 4'd11 || op == 4'd12 ||
               op == 4'd14 || op == 4'd15;
    endfunction

    function automatic logic mem_inverted(input logic [3:0] op);
        return op == 4'd9 || op == 4'd12 || op == 4'd15;
    endfunction

endpackage

`default_nettype wire

// File: sv/vector_isa_instruction_decoder_core.sv
// three-stage vector isa instruction decoder with stream ports
// depends on visa_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

// channel   dir  tdata fields, lowest bit first
// s_axis    in   instruction_word[31:0], instruction_address[63:32]
// m_axis    out  format_class, op_code, dest_reg, src1_reg, src2_reg, mask_reg,
//                immediate, branch_target, operand_kinds, mask_mode, type_flags,
//                memory_kind, one pad bit
//
// one request per cycle sustained while the output side does not stall; an accepted request
// passes the stage 1, stage 2 and stage 3 registers before tvalid rises with its result
// stage 1 classifies, stage 2 extracts fields and flags, stage 3 adds the target
// each stage moves when the stage after it is empty or moving, so a stall on
// the output side fills the bubbles first and never drops or repeats a request
// synchronous active-low reset clears the stage valid bits only

module vector_isa_instruction_decoder_core
    import visa_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    output logic                  o_s_tready,
    input  wire logic [IN_W-1:0]  i_s_tdata,   // instruction_word, instruction_address
    output logic                  o_m_tvalid,
    input  wire logic             i_m_tready,
    output logic [OUT_W-1:0]      o_m_tdata    // format_class .. memory_kind, pad
);

    logic        en1, en2, en3;
    logic        r_v1, r_v2, r_v3;
    logic [31:0] r1_word, r1_addr, r2_addr;
    t_fmt_class  r1_cls, n1_cls;
    t_dec_fields r2_dec, n2_dec, r3_dec;
    logic        r2_tgt_en, n2_tgt_en;
    logic [31:0] r3_tgt, n3_tgt;

    // stage advance chain
    assign en3        = !r_v3 || i_m_tready;
    assign en2        = !r_v2 || en3;
    assign en1        = !r_v1 || en2;
    assign o_s_tready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_s_tvalid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    // stage 1: classify the word
    always_comb begin
        logic [31:0] w;
        w = i_s_tdata[31:0];
        if (w == 32'd0) begin
            n1_cls = CLS_NOP;
        end else if (w[31:29] == 3'b110) begin
            n1_cls = CLS_A;
        end else if (!w[31]) begin
            n1_cls = CLS_B;
        end else if (w[31:30] == 2'b10) begin
            n1_cls = CLS_C;
        end else if (!w[28]) begin
            n1_cls = (w[27:25] <= DTYPE_BARRIER) ? CLS_D : CLS_UNDEF;
        end else begin
            n1_cls = (w[27:25] <= ETYPE_LAST) ? CLS_E : CLS_UNDEF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_word <= i_s_tdata[31:0];
            r1_addr <= i_s_tdata[63:32];
            r1_cls  <= n1_cls;
        end
    end

    // stage 2: fields, immediate and flags
    always_comb begin
        logic [31:0] w;
        logic [2:0]  f;
        logic [5:0]  opc;
        logic [3:0]  mop;
        logic [1:0]  acc;
        logic        cmp, fl, sd, masked;
        w         = r1_word;
        f         = 3'd0;
        opc       = 6'd0;
        mop       = w[28:25];
        acc       = mem_access(mop);
        cmp       = 1'b0;
        fl        = 1'b0;
        sd        = 1'b0;
        masked    = 1'b0;
        n2_dec    = '0;
        n2_tgt_en = 1'b0;
        n2_dec.fmt_class = r1_cls;
        case (r1_cls)
            CLS_NOP: begin
            end
            CLS_A: begin
                f      = w[22:20];
                opc    = w[28:23];
                cmp    = op_is_cmp(opc);
                fl     = op_is_float(opc);
                sd     = cmp || opc == OPC_GETLANE;
                masked = fmt_masked(f) && !cmp;
                n2_dec.op_code  = opc;
                n2_dec.dest_reg = w[9:5];
                n2_dec.src1_reg = w[4:0];
                n2_dec.src2_reg = w[19:15];
                n2_dec.operand_kinds = {(opc != OPC_SHUFFLE) && (f <= 3'd3),
                                        f == 3'd0, sd || f == 3'd0};
                if (masked) begin
                    n2_dec.mask_mode = fmt_inverted(f) ? 2'd2 : 2'd1;
                    n2_dec.mask_reg  = w[14:10];
                end
                n2_dec.type_flags = {opc == OPC_MOVE, cmp, op_is_uns(opc),
                                     !sd && fl && opc != OPC_FTOI,
                                     fl && opc != OPC_ITOF};
            end
            CLS_B: begin
                f      = w[25:23];
                opc    = {1'b0, w[30:26]};
                cmp    = op_is_cmp(opc);
                masked = fmt_masked(f) && !cmp;
                n2_dec.op_code  = opc;
                n2_dec.dest_reg = w[9:5];
                n2_dec.src1_reg = w[4:0];
                n2_dec.operand_kinds = {1'b0, b_op1_scalar(f),
                                        cmp || opc == OPC_GETLANE || f == 3'd0};
                if (masked) begin
                    n2_dec.mask_mode = fmt_inverted(f) ? 2'd2 : 2'd1;
                    n2_dec.mask_reg  = w[14:10];
                    n2_dec.immediate = {{12{w[22]}}, w[22:15]};
                end else begin
                    n2_dec.immediate = {{7{w[22]}}, w[22:10]};
                end
                // or with zero immediate is a plain copy
                n2_dec.type_flags = {(opc == OPC_OR && n2_dec.immediate == 20'd0) ||
                                     opc == OPC_MOVE,
                                     cmp, op_is_uns(opc), 1'b0, op_is_float(opc)};
            end
            CLS_C: begin
                n2_dec.op_code   = {2'b00, mop};
                n2_dec.dest_reg  = w[9:5];
                n2_dec.src1_reg  = w[4:0];
                n2_dec.immediate = {{10{w[24]}}, w[24:15]};
                if (mop == MOP_CTRL) begin
                    n2_dec.memory_kind   = {1'b1, w[29], 2'b00};
                    n2_dec.operand_kinds = 3'b001;
                end else begin
                    n2_dec.memory_kind   = {1'b0, w[29], acc};
                    n2_dec.operand_kinds = {1'b0, acc != ACC_GATHER, acc == ACC_SCALAR};
                    if (mem_masked(mop)) begin
                        n2_dec.mask_mode = mem_inverted(mop) ? 2'd2 : 2'd1;
                        n2_dec.mask_reg  = w[14:10];
                    end
                    // zero-extending scalar loads
                    if (w[29] && acc == ACC_SCALAR && mop != MOP_LOAD_S8 &&
                        mop != MOP_LOAD_S16) begin
                        n2_dec.type_flags = 5'b00100;
                    end
                end
            end
            CLS_D, CLS_E, CLS_UNDEF: begin
                n2_dec.op_code = {3'b000, w[27:25]};
                if (w[28]) begin
                    // branch
                    if (w[27:25] != ETYPE_GOTO && w[27:25] != ETYPE_CALL) begin
                        n2_dec.src1_reg      = w[4:0];
                        n2_dec.operand_kinds = 3'b010;
                    end
                    if (w[27:25] != ETYPE_CALL_REG) begin
                        n2_dec.immediate = w[24:5];
                        n2_tgt_en        = 1'b1;
                    end
                end else if (w[27:25] != DTYPE_BARRIER) begin
                    // cache control
                    n2_dec.src1_reg      = w[4:0];
                    n2_dec.immediate     = {{10{w[24]}}, w[24:15]};
                    n2_dec.operand_kinds = 3'b010;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_dec    <= n2_dec;
            r2_addr   <= r1_addr;
            r2_tgt_en <= n2_tgt_en;
        end
    end

    // stage 3: branch target, output register
    assign n3_tgt = r2_tgt_en ?
                    r2_addr + 32'd4 + {{12{r2_dec.immediate[19]}}, r2_dec.immediate} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_dec <= r2_dec;
            r3_tgt <= n3_tgt;
        end
    end

    // output packing
    assign o_m_tvalid = r_v3;
    assign o_m_tdata  = {1'b0, r3_dec.memory_kind, r3_dec.type_flags, r3_dec.mask_mode,
                         r3_dec.operand_kinds, r3_tgt, r3_dec.immediate,
                         r3_dec.mask_reg, r3_dec.src2_reg, r3_dec.src1_reg,
                         r3_dec.dest_reg, r3_dec.op_code, r3_dec.fmt_class};

    // checks
    `ASSERT_NEXT(a_accept_fills, i_s_tvalid && o_s_tready, r_v1, "accepted request lost in stage 1")
    `ASSERT_IMPL(a_nop_zero, r_v3 && r3_dec.fmt_class == CLS_NOP, o_m_tdata[94:3] == 92'd0, "nop with nonzero fields")
    `ASSERT_IMPL(a_mask_reg, r_v3 && r3_dec.mask_mode == 2'd0, r3_dec.mask_reg == 5'd0, "mask register without masking")
    `ASSERT_IMPL(a_tgt_class, r_v3 && r3_dec.fmt_class != CLS_E && r3_dec.fmt_class != CLS_UNDEF, r3_tgt == 32'd0, "branch target outside branch class")
    `ASSERT_ALWAYS(a_mask_mode, !r_v3 || r3_dec.mask_mode != 2'd3, "invalid mask mode")

endmodule

`default_nettype wire

// File: verif/visa_decode_checker.sv
// request/result checker for the vector isa decoder: predicts each decode and compares it
// depends on visa_pkg for the class enum and the named opcodes and types
module visa_decode_checker
    import visa_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  logic             i_s_tready,
    input  logic [IN_W-1:0]  i_s_tdata,   // instruction_word, instruction_address
    input  logic             i_m_tvalid,
    input  logic             i_m_tready,
    input  logic [OUT_W-1:0] i_m_tdata,   // format_class .. memory_kind, pad
    output int               o_fail_count,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // result layout, msb first so that the struct maps straight onto tdata
    typedef struct packed {
        logic        pad;
        logic [3:0]  memory_kind;
        logic [4:0]  type_flags;
        logic [1:0]  mask_mode;
        logic [2:0]  operand_kinds;
        logic [31:0] branch_target;
        logic [19:0] immediate;
        logic [4:0]  mask_reg;
        logic [4:0]  src2_reg;
        logic [4:0]  src1_reg;
        logic [4:0]  dest_reg;
        logic [5:0]  op_code;
        t_fmt_class  fmt_class;
    } t_decoded;

    typedef struct {
        logic [IN_W-1:0] req;
        t_decoded        dec;
    } t_pending_decode;

    // mask modes
    localparam logic [1:0] MMODE_ON  = 2'd1;
    localparam logic [1:0] MMODE_INV = 2'd2;

    // memory access kinds not named in the package
    localparam logic [1:0] ACC_BLOCK   = 2'd1;
    localparam logic [1:0] ACC_STRIDED = 2'd2;

    localparam logic [4:0] TF_UNSIGNED = 5'b00100;

    // opcode property sets, one bit per opcode
    localparam logic [63:0] FLOAT_OPS = 64'h0000_F6CF_1800_0000;
    localparam logic [63:0] CMP_OPS   = 64'h0000_F000_07FF_0000;
    localparam logic [63:0] UNS_OPS   = 64'h0000_0000_03C0_0400;

    // a/b format properties, one bit per format value
    localparam logic [7:0] A_OP1_SCALAR = 8'b0000_0001;
    localparam logic [7:0] A_OP2_SCALAR = 8'b0000_1111;
    localparam logic [7:0] B_DST_SCALAR = 8'b0000_0001;
    localparam logic [7:0] B_OP1_SCALAR = 8'b0111_0001;
    localparam logic [7:0] AB_MASKED    = 8'b0110_1100;
    localparam logic [7:0] AB_INVERTED  = 8'b0100_1000;

    // memory op properties, one bit per op
    localparam logic [15:0] C_MASKED   = 16'hDB00;
    localparam logic [15:0] C_INVERTED = 16'h9200;

    t_pending_decode expected_decodes[$];
    t_pending_decode head;
    t_decoded        seen_dec;
    int              errors = 0;

    // full decode of one instruction word
    function automatic t_decoded decode_instruction(input logic [31:0] w,
                                                    input logic [31:0] addr);
        t_decoded   d;
        logic [2:0] f;
        logic [3:0] mop;
        logic [1:0] acc;
        logic [5:0] opc;
        logic       cmp;
        logic       fl;
        logic       sd;
        d = '0;
        if (w == 32'd0) begin
            d.fmt_class = CLS_NOP;
        end else if (w[31:29] == 3'b110) begin
            // register-register
            f   = w[22:20];
            opc = w[28:23];
            cmp = CMP_OPS[opc];
            fl  = FLOAT_OPS[opc];
            sd  = cmp || opc == OPC_GETLANE;
            d.fmt_class = CLS_A;
            d.op_code   = opc;
            d.dest_reg  = w[9:5];
            d.src1_reg  = w[4:0];
            d.src2_reg  = w[19:15];
            d.operand_kinds = {A_OP2_SCALAR[f] && opc != OPC_SHUFFLE, A_OP1_SCALAR[f],
                               sd || A_OP1_SCALAR[f]};
            if (AB_MASKED[f] && !cmp) begin
                d.mask_mode = AB_INVERTED[f] ? MMODE_INV : MMODE_ON;
                d.mask_reg  = w[14:10];
            end
            d.type_flags = {opc == OPC_MOVE, cmp, UNS_OPS[opc],
                            !sd && fl && opc != OPC_FTOI, fl && opc != OPC_ITOF};
        end else if (!w[31]) begin
            // immediate, 8 bits when masked else 13
            f   = w[25:23];
            opc = {1'b0, w[30:26]};
            cmp = CMP_OPS[opc];
            d.fmt_class = CLS_B;
            d.op_code   = opc;
            d.dest_reg  = w[9:5];
            d.src1_reg  = w[4:0];
            d.operand_kinds = {1'b0, B_OP1_SCALAR[f],
                               cmp || opc == OPC_GETLANE || B_DST_SCALAR[f]};
            if (AB_MASKED[f] && !cmp) begin
                d.mask_mode = AB_INVERTED[f] ? MMODE_INV : MMODE_ON;
                d.mask_reg  = w[14:10];
                d.immediate = {{12{w[22]}}, w[22:15]};
            end else begin
                d.immediate = {{7{w[22]}}, w[22:10]};
            end
            d.type_flags = {(opc == OPC_OR && d.immediate == 20'd0) || opc == OPC_MOVE,
                            cmp, UNS_OPS[opc], 1'b0, FLOAT_OPS[opc]};
        end else if (!w[30]) begin
            // memory access
            mop = w[28:25];
            acc = (mop < 4'd7)  ? ACC_SCALAR :
                  (mop < 4'd10) ? ACC_BLOCK :
                  (mop < 4'd13) ? ACC_STRIDED : ACC_GATHER;
            d.fmt_class = CLS_C;
            d.op_code   = {2'b00, mop};
            d.dest_reg  = w[9:5];
            d.src1_reg  = w[4:0];
            d.immediate = {{10{w[24]}}, w[24:15]};
            if (mop == MOP_CTRL) begin
                d.memory_kind   = {1'b1, w[29], 2'b00};
                d.operand_kinds = 3'b001;
            end else begin
                d.memory_kind   = {1'b0, w[29], acc};
                d.operand_kinds = {1'b0, acc != ACC_GATHER, acc == ACC_SCALAR};
                if (C_MASKED[mop]) begin
                    d.mask_mode = C_INVERTED[mop] ? MMODE_INV : MMODE_ON;
                    d.mask_reg  = w[14:10];
                end
                if (w[29] && acc == ACC_SCALAR && mop != MOP_LOAD_S8 && mop != MOP_LOAD_S16)
                    d.type_flags = TF_UNSIGNED;
            end
        end else if (!w[28]) begin
            // cache control, barrier carries no register
            d.op_code   = {3'b000, w[27:25]};
            d.fmt_class = (w[27:25] > DTYPE_BARRIER) ? CLS_UNDEF : CLS_D;
            if (w[27:25] != DTYPE_BARRIER) begin
                d.src1_reg      = w[4:0];
                d.immediate     = {{10{w[24]}}, w[24:15]};
                d.operand_kinds = 3'b010;
            end
        end else begin
            // branch, target wraps at 32 bits
            d.op_code   = {3'b000, w[27:25]};
            d.fmt_class = (w[27:25] > ETYPE_LAST) ? CLS_UNDEF : CLS_E;
            if (w[27:25] != ETYPE_GOTO && w[27:25] != ETYPE_CALL) begin
                d.src1_reg      = w[4:0];
                d.operand_kinds = 3'b010;
            end
            if (w[27:25] != ETYPE_CALL_REG) begin
                d.immediate     = w[24:5];
                d.branch_target = addr + 32'd4 + {{12{w[24]}}, w[24:5]};
            end
        end
        return d;
    endfunction

    task automatic show_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
        if (want !== got)
            $display("    %s: expected %0h, got %0h", name, want, got);
    endtask

    // requests push a predicted decode, results are compared with the oldest
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_m_tvalid && i_m_tready) begin
                seen_dec = t_decoded'(i_m_tdata);
                if (expected_decodes.size() == 0) begin
                    if (errors < 10)
                        $display("[%0t] result with no request outstanding: %h",
                                 $realtime, i_m_tdata);
                    errors++;
                end else begin
                    head = expected_decodes.pop_front();
                    if (head.dec !== seen_dec) begin
                        if (errors < 10) begin
                            $display("[%0t] decode mismatch, word %h address %h", $realtime,
                                     head.req[31:0], head.req[63:32]);
                            show_field("format_class", 32'(head.dec.fmt_class),
                                       32'(seen_dec.fmt_class));
                            show_field("op_code", 32'(head.dec.op_code),
                                       32'(seen_dec.op_code));
                            show_field("dest_reg", 32'(head.dec.dest_reg),
                                       32'(seen_dec.dest_reg));
                            show_field("src1_reg", 32'(head.dec.src1_reg),
                                       32'(seen_dec.src1_reg));
                            show_field("src2_reg", 32'(head.dec.src2_reg),
                                       32'(seen_dec.src2_reg));
                            show_field("mask_reg", 32'(head.dec.mask_reg),
                                       32'(seen_dec.mask_reg));
                            show_field("immediate", 32'(head.dec.immediate),
                                       32'(seen_dec.immediate));
                            show_field("branch_target", head.dec.branch_target,
                                       seen_dec.branch_target);
                            show_field("operand_kinds", 32'(head.dec.operand_kinds),
                                       32'(seen_dec.operand_kinds));
                            show_field("mask_mode", 32'(head.dec.mask_mode),
                                       32'(seen_dec.mask_mode));
                            show_field("type_flags", 32'(head.dec.type_flags),
                                       32'(seen_dec.type_flags));
                            show_field("memory_kind", 32'(head.dec.memory_kind),
                                       32'(seen_dec.memory_kind));
                            show_field("pad", 32'(head.dec.pad), 32'(seen_dec.pad));
                        end
                        errors++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                head.req = i_s_tdata;
                head.dec = decode_instruction(i_s_tdata[31:0], i_s_tdata[63:32]);
                expected_decodes.push_back(head);
            end
        end
        o_fail_count <= errors;
        o_pending    <= expected_decodes.size();
    end

endmodule

// File: verif/tb_vector_isa_instruction_decoder_core.sv
// testbench top for vector_isa_instruction_decoder_core: clock, reset, requests, verdict
// depends on visa_pkg, the decoder rtl and visa_decode_checker
module tb_vector_isa_instruction_decoder_core;
    import visa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1650;
    localparam int CYCLE_LIMIT  = 200000;

    // opcodes used by the directed requests
    localparam logic [5:0] OPC_INT_CMP = 6'd20;
    localparam logic [5:0] OPC_FLT_CMP = 6'd45;
    localparam logic [5:0] OPC_FLT_ADD = 6'd32;
    localparam logic [5:0] OPC_NO_ENTRY = 6'd63;
    localparam logic [3:0] MOP_LOAD_U32 = 4'd2;
    localparam logic [3:0] MOP_STORE_BLK_M = 4'd8;
    localparam logic [3:0] MOP_GATHER_INV = 4'd15;
    localparam logic [2:0] DTYPE_FIRST = 3'd0;
    localparam logic [2:0] DTYPE_UNDEF = 3'd5;
    localparam logic [2:0] ETYPE_COND = 3'd0;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             s_tready;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             idle_en = 1'b1;
    int               fail_count;
    int               pending;
    int               cycles = 0;

    always #5 clk = ~clk;

    vector_isa_instruction_decoder_core DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    visa_decode_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // result side back-pressure
    always @(posedge clk) begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= idle_en ? ($urandom_range(99) >= 27) : 1'b1;
    end

    // run watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // one request, with optional idle cycles ahead of it
    task automatic send_request(input logic [31:0] word, input logic [31:0] addr);
        while (idle_en && $urandom_range(99) < 27) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {addr, word};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // random word, biased toward each class with random content
    function automatic logic [31:0] random_instruction();
        logic [31:0] w;
        int unsigned pick;
        w    = $urandom;
        pick = $urandom_range(99);
        if (pick < 30) begin
            w[31:29] = 3'b110;
        end else if (pick < 55) begin
            w[31] = 1'b0;
            if ($urandom_range(9) == 0) begin
                w[30:26] = OPC_OR[4:0];
                w[22:10] = 13'd0;
            end
        end else if (pick < 75) begin
            w[31:30] = 2'b10;
        end else if (pick < 86) begin
            w[31:28] = 4'b1110;
        end else if (pick < 97) begin
            w[31:28] = 4'b1111;
        end else if (pick < 98) begin
            w = 32'd0;
        end
        return w;
    endfunction

    initial begin
        logic [31:0] addr;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes and special cases of every class
        send_request(32'h0000_0000, 32'h0000_0000);                      // nop
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);                      // undefined branch type
        send_request(32'hDFFF_FFFF, 32'h0000_0000);                      // a, no table entry
        send_request({3'b110, OPC_SHUFFLE, 3'd0, 5'd3, 5'd4, 5'd5, 5'd6}, 32'h100);
        send_request({3'b110, OPC_ITOF, 3'd6, 5'd1, 5'd2, 5'd3, 5'd4}, 32'h104);
        send_request({3'b110, OPC_FTOI, 3'd2, 5'd9, 5'd8, 5'd7, 5'd6}, 32'h108);
        send_request({3'b110, OPC_GETLANE, 3'd4, 5'd31, 5'd0, 5'd31, 5'd0}, 32'h10C);
        send_request({3'b110, OPC_INT_CMP, 3'd3, 5'd11, 5'd12, 5'd13, 5'd14}, 32'h110);
        send_request({3'b110, OPC_FLT_CMP, 3'd5, 5'd1, 5'd1, 5'd1, 5'd1}, 32'h114);
        send_request({3'b110, OPC_MOVE, 3'd1, 5'd2, 5'd3, 5'd4, 5'd5}, 32'h118);
        send_request({3'b110, OPC_FLT_ADD, 3'd7, 5'd2, 5'd3, 5'd4, 5'd5}, 32'h11C);
        send_request({3'b110, OPC_NO_ENTRY, 3'd0, 5'd0, 5'd0, 5'd0, 5'd0}, 32'h120);
        send_request({1'b0, OPC_OR[4:0], 3'd1, 13'd0, 5'd7, 5'd9}, 32'h124);  // copy
        send_request({1'b0, OPC_INT_CMP[4:0], 3'd2, 13'h1000, 5'd1, 5'd2}, 32'h128);
        send_request({1'b0, 5'd1, 3'd5, 8'h80, 5'd17, 5'd2, 5'd3}, 32'h12C);
        send_request({1'b0, OPC_MOVE[4:0], 3'd6, 13'h0FFF, 5'd4, 5'd5}, 32'h130);
        send_request(32'h7FFF_FFFF, 32'h134);
        send_request(32'h8000_0000, 32'h138);                            // scalar store
        send_request({2'b10, 1'b1, MOP_CTRL, 10'h200, 5'd31, 5'd1, 5'd2}, 32'h13C);
        send_request({2'b10, 1'b1, MOP_LOAD_S8, 10'h1FF, 5'd0, 5'd3, 5'd4}, 32'h140);
        send_request({2'b10, 1'b1, MOP_LOAD_U32, 10'h001, 5'd6, 5'd5, 5'd4}, 32'h144);
        send_request({2'b10, 1'b0, MOP_STORE_BLK_M, 10'h3FF, 5'd9, 5'd8, 5'd7}, 32'h148);
        send_request({2'b10, 1'b1, MOP_GATHER_INV, 10'h155, 5'd21, 5'd22, 5'd23}, 32'h14C);
        send_request({4'b1110, DTYPE_BARRIER, 25'h1FF_FFFF}, 32'h150);
        send_request({4'b1110, DTYPE_FIRST, 10'h3FF, 10'd0, 5'd5}, 32'h154);
        send_request({4'b1110, DTYPE_UNDEF, 10'h200, 10'h3FF, 5'd17}, 32'h158);
        send_request({4'b1111, ETYPE_GOTO, 20'h80000, 5'd7}, 32'h0000_0000);
        send_request({4'b1111, ETYPE_CALL_REG, 20'hFFFFF, 5'd3}, 32'h0000_1000);
        send_request({4'b1111, ETYPE_COND, 20'h00001, 5'd31}, 32'hFFFF_FFFC);

        // random part with a stretch free of idles and back-pressure and one full drain midway
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            idle_en <= !(n >= 700 && n < 1050);
            if (n == 1200) begin
                s_tvalid <= 1'b0;
                do @(posedge clk); while (pending != 0);
            end
            addr = ($urandom_range(7) == 0) ? {24'hFFFF_FF, 8'($urandom)} : $urandom;
            send_request(random_instruction(), addr);
        end
        s_tvalid <= 1'b0;

        // drain, then allow for any stray late result
        do @(posedge clk); while (pending != 0);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: files.f
+incdir+sv
sv/visa_pkg.sv
sv/vector_isa_instruction_decoder_core.sv
verif/visa_decode_checker.sv
verif/tb_vector_isa_instruction_decoder_core.sv
